@@ rtl/core/mcdw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcdw_pkg: shared definitions for the double-well Monte Carlo walker
// Fixed-point formats, sequencer codes, control struct and logistic table.
// ----------------------------------------------------------------------------
package mcdw_pkg;

  // Fixed-point and sizing constants
  localparam int COUNT_BITS     = 20;
  localparam int FRAC_BITS      = 12;
  localparam int LOGISTIC_DEPTH = 256;
  localparam int LOG_IDX_W      = $clog2(LOGISTIC_DEPTH);

  // p = beta*|dU| is Q.(F+8); table covers |z| in [0,16)
  localparam int IDX_SHIFT      = FRAC_BITS + 12 - LOG_IDX_W;

  // Shared multiplier operand and product widths
  localparam int MUL_W  = 25;
  localparam int PROD_W = 2 * MUL_W;

  localparam logic [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [23:0]       ONE_Q    = 24'(1) << FRAC_BITS;
  localparam logic [23:0]       ENERGY_MAX = 24'hFF_FFFF;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [15:0]       BETA_RESET = 16'd2560;

  // Sequencer state codes
  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE = 3'd0;  // wait for input, square x
  localparam logic [ST_W-1:0] ST_SQ   = 3'd1;  // update sums, square trial x
  localparam logic [ST_W-1:0] ST_NE   = 3'd2;  // square (s-1)
  localparam logic [ST_W-1:0] ST_DU   = 3'd3;  // trial energy, beta*|dU|
  localparam logic [ST_W-1:0] ST_LOOK = 3'd4;  // table lookup
  localparam logic [ST_W-1:0] ST_DONE = 3'd5;  // decide and report

  // Phase strobes from the sequencer to the datapath
  typedef struct packed {
    logic idle;
    logic sq;
    logic ne;
    logic du;
    logic look;
    logic fin;   // result is loaded into the output register this cycle
  } mcdw_ctrl_t;

  typedef logic [15:0] logistic_table_t [LOGISTIC_DEPTH];

  // Magnitude of a signed 16-bit position
  function automatic logic [16:0] abs16(input logic signed [15:0] x);
    logic signed [16:0] e;
    e = 17'(x);
    return e[16] ? 17'(-e) : 17'(e);
  endfunction

  // Logistic table: floor(65536*e^-z/(1+e^-z)) at z = 16*i/DEPTH,
  // e^-z from a Q31 Taylor term for z/256 squared eight times.
  function automatic logistic_table_t build_logistic();
    logistic_table_t tab;
    logic [63:0] one;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] t3;
    logic [63:0] t4;
    logic [63:0] u;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] rem;
    logic [63:0] quo;
    one = 64'd1 << 31;
    for (int i = 0; i < LOGISTIC_DEPTH; i++) begin
      // DEPTH*16 is a power of two: z/256 in Q31 is a plain shift of i
      t  = 64'(i) << (31 - LOG_IDX_W - 4);
      t2 = (t * t) >> 31;
      t3 = (t2 * t) >> 31;
      t4 = (t3 * t) >> 31;
      u  = one - t + t2 / 64'd2 - t3 / 64'd6 + t4 / 64'd24;
      for (int k = 0; k < 8; k++) begin
        u = (u * u + (64'd1 << 30)) >> 31;
      end
      // 65536*u/(1+u) by restoring long division; u <= 2^31
      num = u << 16;
      den = one + u;
      rem = '0;
      quo = '0;
      for (int b = 47; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        if (rem >= den) begin
          rem    = rem - den;
          quo[b] = 1'b1;
        end
      end
      tab[i] = quo[15:0];
    end
    return tab;
  endfunction

  localparam logistic_table_t LOGISTIC_TABLE = build_logistic();

endpackage
`default_nettype wire

@@ rtl/core/mcdw_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcdw_mul: shared unsigned multiplier
// One registered 25x25 product, reused for every multiply of a step.
// ----------------------------------------------------------------------------
module mcdw_mul (
  input  wire logic                        clk,
  input  wire logic [mcdw_pkg::MUL_W-1:0]  op_a,
  input  wire logic [mcdw_pkg::MUL_W-1:0]  op_b,
  output logic      [mcdw_pkg::PROD_W-1:0] prod
);

  logic [mcdw_pkg::PROD_W-1:0] prod_r;

  // Product register; operands change every phase
  always_ff @(posedge clk) begin
    prod_r <= mcdw_pkg::PROD_W'(op_a) * mcdw_pkg::PROD_W'(op_b);
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

@@ rtl/core/mcdw_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcdw_seq: step sequencer
// Walks the six phases of one Monte Carlo step and drives the datapath.
// ----------------------------------------------------------------------------
module mcdw_seq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_fire,
  input  wire logic                 out_free,
  output logic                      in_rdy,
  output mcdw_pkg::mcdw_ctrl_t      ctrl
);

  logic [mcdw_pkg::ST_W-1:0] state_r;
  logic [mcdw_pkg::ST_W-1:0] state_nxt;

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mcdw_pkg::ST_IDLE: if (in_fire) state_nxt = mcdw_pkg::ST_SQ;
      mcdw_pkg::ST_SQ:   state_nxt = mcdw_pkg::ST_NE;
      mcdw_pkg::ST_NE:   state_nxt = mcdw_pkg::ST_DU;
      mcdw_pkg::ST_DU:   state_nxt = mcdw_pkg::ST_LOOK;
      mcdw_pkg::ST_LOOK: state_nxt = mcdw_pkg::ST_DONE;
      mcdw_pkg::ST_DONE: if (out_free) state_nxt = mcdw_pkg::ST_IDLE;
      default:           state_nxt = mcdw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mcdw_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Phase strobes
  always_comb begin
    ctrl.idle = (state_r == mcdw_pkg::ST_IDLE);
    ctrl.sq   = (state_r == mcdw_pkg::ST_SQ);
    ctrl.ne   = (state_r == mcdw_pkg::ST_NE);
    ctrl.du   = (state_r == mcdw_pkg::ST_DU);
    ctrl.look = (state_r == mcdw_pkg::ST_LOOK);
    ctrl.fin  = (state_r == mcdw_pkg::ST_DONE) && out_free;
  end

  assign in_rdy = (state_r == mcdw_pkg::ST_IDLE);

endmodule
`default_nettype wire

@@ rtl/core/barker_monte_carlo_double_well.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// barker_monte_carlo_double_well: double-well walker, logistic acceptance
// Reports the current state and running sums, then tries one move.
// ----------------------------------------------------------------------------
// Each input transaction is one Monte Carlo step and yields exactly one
// result transaction. After the accepting edge the sequencer passes
// through the SQ, NE, DU, LOOK and DONE phases; the result register loads
// as DONE is left, and the block then returns to idle for the next step.
// One shared 25x25 multiplier computes x^2, the trial x^2, the trial (s-1)^2
// and beta*|dU| in turn, then the logistic table is read and the move decided.
// in_ready is high only while the block waits for a step; a finished result
// held in the output register does not block the next input, but the step
// after it waits in its last phase until that result is taken.
// The beta register (cfg_data, unsigned Q8.8) may be written whenever the
// block is idle; cfg_ready is always high.
// ----------------------------------------------------------------------------
module barker_monte_carlo_double_well (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [15:0]        cfg_data,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [14:0] in_trial_step,
  input  wire logic [15:0]        in_uniform_draw,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [19:0]             out_step_number,
  output logic [23:0]             out_energy,
  output logic signed [15:0]      out_position,
  output logic [18:0]             out_position_squared,
  output logic [43:0]             out_energy_total,
  output logic signed [35:0]      out_position_total,
  output logic [38:0]             out_square_total,
  output logic                    out_move_accepted
);

  localparam int MW = mcdw_pkg::MUL_W;
  localparam int PW = mcdw_pkg::PROD_W;
  localparam int FB = mcdw_pkg::FRAC_BITS;

  mcdw_pkg::mcdw_ctrl_t ctrl;
  logic                 in_fire;
  logic                 out_free;
  logic                 in_rdy;

  // Walker state
  logic [15:0]                     beta_r;
  logic signed [15:0]              pos_r;
  logic [23:0]                     energy_r;
  logic [mcdw_pkg::COUNT_BITS-1:0] count_r;
  logic [43:0]                     esum_r;
  logic signed [35:0]              psum_r;
  logic [38:0]                     ssum_r;

  // Per-step working registers
  logic signed [15:0] np_r;
  logic [15:0]        draw_r;
  logic [18:0]        sq_r;
  logic [23:0]        ne_r;
  logic               du_neg_r;
  logic [16:0]        b_r;

  // Result register
  logic               out_valid_r;
  logic [19:0]        o_step_r;
  logic [23:0]        o_energy_r;
  logic signed [15:0] o_pos_r;
  logic [18:0]        o_sq_r;
  logic [43:0]        o_esum_r;
  logic signed [35:0] o_psum_r;
  logic [38:0]        o_ssum_r;
  logic               o_acc_r;

  // Shared multiplier
  logic [MW-1:0] op_a;
  logic [MW-1:0] op_b;
  logic [PW-1:0] prod;

  // Datapath intermediates
  logic signed [16:0] np_wide;
  logic signed [15:0] np_sat;
  logic [PW-1:0]      rnd;
  logic [18:0]        sq_now;
  logic signed [19:0] sdiff;
  logic [19:0]        m_abs;
  logic [23:0]        ne_now;
  logic signed [24:0] du;
  logic [24:0]        du_mag;
  logic [PW-1:0]      p_idx;
  logic [mcdw_pkg::LOG_IDX_W-1:0] idx;
  logic [15:0]        entry;
  logic [44:0]        esum_add;
  logic signed [36:0] psum_add;
  logic [39:0]        ssum_add;
  logic               accept;

  assign in_fire  = in_valid && in_rdy;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = in_rdy;
  assign cfg_ready = 1'b1;

  mcdw_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .in_rdy   (in_rdy),
    .ctrl     (ctrl)
  );

  mcdw_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  // Trial position, saturated to 16 bits
  always_comb begin
    np_wide = 17'(pos_r) + 17'(in_trial_step);
    if (np_wide > 17'sd32767) begin
      np_sat = 16'sh7FFF;
    end else if (np_wide < -17'sd32768) begin
      np_sat = 16'sh8000;
    end else begin
      np_sat = np_wide[15:0];
    end
  end

  // Rounded Q shift of the product, used by squares and energy
  assign rnd    = (prod + mcdw_pkg::HALF_LSB) >> FB;
  assign sq_now = rnd[18:0];

  // |s - 1| for the trial energy
  always_comb begin
    sdiff = $signed({1'b0, sq_now}) - $signed({1'b0, 19'(mcdw_pkg::ONE_Q)});
    m_abs = sdiff[19] ? 20'(-sdiff) : 20'(sdiff);
  end

  // Trial energy, saturated, and the signed energy difference
  always_comb begin
    ne_now = (rnd > PW'(mcdw_pkg::ENERGY_MAX)) ? mcdw_pkg::ENERGY_MAX : rnd[23:0];
    du     = $signed({1'b0, ne_now}) - $signed({1'b0, energy_r});
    du_mag = du[24] ? 25'(-du) : 25'(du);
  end

  // Table index from beta*|dU|, clipped to the last entry
  always_comb begin
    p_idx = prod >> mcdw_pkg::IDX_SHIFT;
    if (p_idx > PW'(mcdw_pkg::LOGISTIC_DEPTH - 1)) begin
      idx = mcdw_pkg::LOG_IDX_W'(mcdw_pkg::LOGISTIC_DEPTH - 1);
    end else begin
      idx = p_idx[mcdw_pkg::LOG_IDX_W-1:0];
    end
    entry = mcdw_pkg::LOGISTIC_TABLE[idx];
  end

  // Multiplier operand select per phase
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (ctrl.idle) begin
      op_a = MW'(mcdw_pkg::abs16(pos_r));
      op_b = MW'(mcdw_pkg::abs16(pos_r));
    end else if (ctrl.sq) begin
      op_a = MW'(mcdw_pkg::abs16(np_r));
      op_b = MW'(mcdw_pkg::abs16(np_r));
    end else if (ctrl.ne) begin
      op_a = MW'(m_abs);
      op_b = MW'(m_abs);
    end else if (ctrl.du) begin
      op_a = MW'(beta_r);
      op_b = du_mag;
    end
  end

  // Saturating running sums
  assign esum_add = {1'b0, esum_r} + 45'(energy_r);
  assign psum_add = 37'(psum_r) + 37'(pos_r);
  assign ssum_add = {1'b0, ssum_r} + 40'(sq_now);

  assign accept = ({1'b0, draw_r} <= b_r);

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r <= mcdw_pkg::BETA_RESET;
    end else if (cfg_valid) begin
      beta_r <= cfg_data;
    end
  end

  // Walker state and sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      energy_r <= mcdw_pkg::ONE_Q;
      count_r  <= '0;
      esum_r   <= '0;
      psum_r   <= '0;
      ssum_r   <= '0;
    end else begin
      if (ctrl.sq) begin
        if (count_r != mcdw_pkg::COUNT_MAX) count_r <= count_r + 1'b1;
        esum_r <= esum_add[44] ? 44'hFFF_FFFF_FFFF : esum_add[43:0];
        ssum_r <= ssum_add[39] ? 39'h7F_FFFF_FFFF : ssum_add[38:0];
        if (psum_add[36] != psum_add[35]) begin
          psum_r <= psum_add[36] ? {1'b1, 35'd0} : {1'b0, {35{1'b1}}};
        end else begin
          psum_r <= psum_add[35:0];
        end
      end
      if (ctrl.fin && accept) begin
        pos_r    <= np_r;
        energy_r <= ne_r;
      end
    end
  end

  // Working registers of the step in flight
  always_ff @(posedge clk) begin
    if (in_fire) begin
      np_r   <= np_sat;
      draw_r <= in_uniform_draw;
    end
    if (ctrl.sq) sq_r <= sq_now;
    if (ctrl.du) begin
      ne_r     <= ne_now;
      du_neg_r <= du[24];
    end
    if (ctrl.look) b_r <= du_neg_r ? (17'h1_0000 - 17'(entry)) : 17'(entry);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fin) begin
      o_step_r   <= 20'(count_r);
      o_energy_r <= energy_r;
      o_pos_r    <= pos_r;
      o_sq_r     <= sq_r;
      o_esum_r   <= esum_r;
      o_psum_r   <= psum_r;
      o_ssum_r   <= ssum_r;
      o_acc_r    <= accept;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_step_number      = o_step_r;
  assign out_energy           = o_energy_r;
  assign out_position         = o_pos_r;
  assign out_position_squared = o_sq_r;
  assign out_energy_total     = o_esum_r;
  assign out_position_total   = o_psum_r;
  assign out_square_total     = o_ssum_r;
  assign out_move_accepted    = o_acc_r;

endmodule
`default_nettype wire
